/* src/hms_pkg.sv */
// Shared constants for the histogram midtones stretch core.
package hms_pkg;

	// Default sample width in bits.
	localparam int SampleBitsDef = 16;

	// Configuration register indexes.
	localparam logic [2:0] REG_SHADOWS    = 3'd0;
	localparam logic [2:0] REG_MIDTONES   = 3'd1;
	localparam logic [2:0] REG_HIGHLIGHTS = 3'd2;
	localparam logic [2:0] REG_OUT_FLOOR  = 3'd3;
	localparam logic [2:0] REG_OUT_CEIL   = 3'd4;

	// How a sample is resolved.
	typedef enum logic [1:0] {
		SEL_FLOOR = 2'd0,
		SEL_CEIL  = 2'd1,
		SEL_CURVE = 2'd2
	} sel_t;

endpackage

/* src/hms_div_cell.sv */
// One restoring long-division cell: develops one quotient bit per request.
module hms_div_cell #(
	parameter int REM_W  = 16,
	parameter int Q_W    = 16,
	parameter int SIDE_W = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_rdy,
	input  logic [REM_W-1:0]  rem_in,
	input  logic [REM_W-1:0]  den_in,
	input  logic [Q_W-1:0]    q_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	input  logic              out_rdy,
	output logic [REM_W-1:0]  rem_out,
	output logic [REM_W-1:0]  den_out,
	output logic [Q_W-1:0]    q_out,
	output logic [SIDE_W-1:0] side_out
);

	logic              valid_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  den_q;
	logic [Q_W-1:0]    q_q;
	logic [SIDE_W-1:0] side_q;
	logic [REM_W:0]    shifted;
	logic              take;

	assign in_rdy  = !valid_q || out_rdy;
	assign shifted = {rem_in, 1'b0};
	assign take    = shifted >= {1'b0, den_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_rdy) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_valid) begin
			rem_q  <= take ? REM_W'(shifted - {1'b0, den_in}) : REM_W'(shifted);
			den_q  <= den_in;
			q_q    <= {q_in[Q_W-2:0], take};
			side_q <= side_in;
		end
	end

	assign out_valid = valid_q;
	assign rem_out   = rem_q;
	assign den_out   = den_q;
	assign q_out     = q_q;
	assign side_out  = side_q;

endmodule

/* src/histogram_midtones_stretch_core.sv */
// Top level of the histogram midtones stretch core.
// Each request carries one sample and yields one stretched sample. The core takes a new
// request every clock while in_stall is low. The pipeline has one compare stage, a chain
// of SAMPLE_BITS division cells for the normalization, two stages that form the midtones
// numerator and divisor, a second chain of SAMPLE_BITS division cells for the midtones
// curve, a multiply stage for the output map and the output register. Each cell develops
// one quotient bit and hands its partial remainder to its neighbor. A stall at the output
// reaches back through the chain in the same cycle, but only as far as the first empty
// stage, so empty stages fill while the output is held.
// Configuration must be written only while no request is in flight.
module histogram_midtones_stretch_core #(
	parameter int SAMPLE_BITS = hms_pkg::SampleBitsDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [2:0]             cfg_index,
	input  logic [SAMPLE_BITS-1:0] cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] sample_in,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [SAMPLE_BITS-1:0] sample_out
);

	localparam int B    = SAMPLE_BITS;
	localparam int W2   = 2 * B + 1;
	localparam int SW2  = 4 + B;

	// Configuration registers.
	logic [B-1:0] shadows_q, midtones_q, highlights_q, floor_q, ceil_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadows_q    <= '0;
			midtones_q   <= {1'b1, {(B-1){1'b0}}};
			highlights_q <= '1;
			floor_q      <= '0;
			ceil_q       <= '1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				hms_pkg::REG_SHADOWS:    shadows_q    <= cfg_data;
				hms_pkg::REG_MIDTONES:   midtones_q   <= cfg_data;
				hms_pkg::REG_HIGHLIGHTS: highlights_q <= cfg_data;
				hms_pkg::REG_OUT_FLOOR:  floor_q      <= cfg_data;
				hms_pkg::REG_OUT_CEIL:   ceil_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: clip tests and the normalization operands.
	logic          v_s1, rdy_s1;
	hms_pkg::sel_t sel_s1, sel_c;
	logic [B-1:0]  a_s1, rng_s1;
	logic          c1_rdy [0:B];

	always_comb begin
		if (sample_in <= shadows_q) begin
			sel_c = hms_pkg::SEL_FLOOR;
		end else if (sample_in >= highlights_q) begin
			sel_c = hms_pkg::SEL_CEIL;
		end else begin
			sel_c = hms_pkg::SEL_CURVE;
		end
	end

	assign rdy_s1   = !v_s1 || c1_rdy[0];
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			sel_s1 <= sel_c;
			a_s1   <= sample_in - shadows_q;
			rng_s1 <= highlights_q - shadows_q;
		end
	end

	// First cell chain: x = floor(a * 2^B / range).
	logic         c1_v   [0:B];
	logic [B-1:0] c1_rem [0:B];
	logic [B-1:0] c1_den [0:B];
	logic [B-1:0] c1_q   [0:B];
	logic [1:0]   c1_side[0:B];

	assign c1_v[0]    = v_s1;
	assign c1_rem[0]  = a_s1;
	assign c1_den[0]  = rng_s1;
	assign c1_q[0]    = '0;
	assign c1_side[0] = sel_s1;

	for (genvar i = 0; i < B; i++) begin : g_chain1
		hms_div_cell #(.REM_W(B), .Q_W(B), .SIDE_W(2)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (c1_v[i]),
			.in_rdy   (c1_rdy[i]),
			.rem_in   (c1_rem[i]),
			.den_in   (c1_den[i]),
			.q_in     (c1_q[i]),
			.side_in  (c1_side[i]),
			.out_valid(c1_v[i+1]),
			.out_rdy  (c1_rdy[i+1]),
			.rem_out  (c1_rem[i+1]),
			.den_out  (c1_den[i+1]),
			.q_out    (c1_q[i+1]),
			.side_out (c1_side[i+1])
		);
	end

	// Stage 2: the two products of the midtones curve. The numerator equals x*(1-m).
	logic         v_s2, rdy_s2, rdy_s3;
	logic [W2-1:0] p1_s2, p2_s2;
	logic [B-1:0] x_s2;
	logic [1:0]   sel_s2;
	logic         mz_s2, mh_s2;
	logic [B:0]   one_minus_x, one_minus_m;
	logic [2*B+1:0] p1_full, p2_full;

	assign one_minus_x = {1'b1, {B{1'b0}}} - {1'b0, c1_q[B]};
	assign one_minus_m = {1'b1, {B{1'b0}}} - {1'b0, midtones_q};
	assign p1_full     = {1'b0, midtones_q} * one_minus_x;
	assign p2_full     = {1'b0, c1_q[B]} * one_minus_m;

	assign rdy_s2    = !v_s2 || rdy_s3;
	assign c1_rdy[B] = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= c1_v[B];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && c1_v[B]) begin
			p1_s2  <= p1_full[W2-1:0];
			p2_s2  <= p2_full[W2-1:0];
			x_s2   <= c1_q[B];
			sel_s2 <= c1_side[B];
			mz_s2  <= midtones_q == '0;
			mh_s2  <= midtones_q == {1'b1, {(B-1){1'b0}}};
		end
	end

	// Stage 3: the divisor. With zero midtones the curve saturates, so the
	// remainder starts at zero and the result is forced later.
	logic          v_s3;
	logic [W2-1:0] den_s3, rem_s3;
	logic [SW2-1:0] side_s3;
	logic          c2_rdy [0:B];

	assign rdy_s3 = !v_s3 || c2_rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			den_s3  <= p1_s2 + p2_s2;
			rem_s3  <= mz_s2 ? '0 : p2_s2;
			side_s3 <= {sel_s2, mz_s2, mh_s2, x_s2};
		end
	end

	// Second cell chain: y = floor(num * 2^B / den).
	logic           c2_v   [0:B];
	logic [W2-1:0]  c2_rem [0:B];
	logic [W2-1:0]  c2_den [0:B];
	logic [B-1:0]   c2_q   [0:B];
	logic [SW2-1:0] c2_side[0:B];

	assign c2_v[0]    = v_s3;
	assign c2_rem[0]  = rem_s3;
	assign c2_den[0]  = den_s3;
	assign c2_q[0]    = '0;
	assign c2_side[0] = side_s3;

	for (genvar j = 0; j < B; j++) begin : g_chain2
		hms_div_cell #(.REM_W(W2), .Q_W(B), .SIDE_W(SW2)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (c2_v[j]),
			.in_rdy   (c2_rdy[j]),
			.rem_in   (c2_rem[j]),
			.den_in   (c2_den[j]),
			.q_in     (c2_q[j]),
			.side_in  (c2_side[j]),
			.out_valid(c2_v[j+1]),
			.out_rdy  (c2_rdy[j+1]),
			.rem_out  (c2_rem[j+1]),
			.den_out  (c2_den[j+1]),
			.q_out    (c2_q[j+1]),
			.side_out (c2_side[j+1])
		);
	end

	// Stage 4: pick the curve value and scale it by the output span.
	logic           v_s4, rdy_s4, rdy_s5;
	logic [W2-1:0]  prod_s4;
	logic [1:0]     sel_s4;
	logic [B:0]     y_c;
	logic [B-1:0]   mag_c;
	logic [2*B:0]   prod_c;
	logic [SW2-1:0] side_end;

	assign side_end = c2_side[B];

	always_comb begin
		if (side_end[B+1]) begin
			y_c = {1'b1, {B{1'b0}}};
		end else if (side_end[B]) begin
			y_c = {1'b0, side_end[B-1:0]};
		end else begin
			y_c = {1'b0, c2_q[B]};
		end
	end

	assign mag_c  = (ceil_q >= floor_q) ? ceil_q - floor_q : floor_q - ceil_q;
	assign prod_c = y_c * mag_c;

	assign rdy_s4    = !v_s4 || rdy_s5;
	assign c2_rdy[B] = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= c2_v[B];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && c2_v[B]) begin
			prod_s4 <= prod_c;
			sel_s4  <= side_end[B+3:B+2];
		end
	end

	// Stage 5: round up, offset from the floor, clamp and hold for the consumer.
	logic           out_valid_q;
	logic [B-1:0]   sample_out_q, res_c;
	logic [W2-1:0]  rounded;
	logic [B:0]     t_c;
	logic [B+1:0]   up_sum;

	assign rdy_s5  = !out_valid_q || !out_stall;
	assign rounded = prod_s4 + W2'({B{1'b1}});
	assign t_c     = rounded[W2-1:B];
	assign up_sum  = {2'b00, floor_q} + {1'b0, t_c};

	always_comb begin
		case (sel_s4)
			hms_pkg::SEL_FLOOR: res_c = floor_q;
			hms_pkg::SEL_CEIL:  res_c = ceil_q;
			default: begin
				if (ceil_q >= floor_q) begin
					res_c = (up_sum > {2'b00, {B{1'b1}}}) ? '1 : up_sum[B-1:0];
				end else begin
					res_c = (t_c > {1'b0, floor_q}) ? '0 : B'({1'b0, floor_q} - t_c);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_s5) begin
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			sample_out_q <= res_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// The input is held off only while the first stage is occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1) else $error("input stalled with empty first stage");

	// An accepted request always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1) else $error("accepted request lost");

	// A finished product moves into an empty output register.
	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !out_valid_q) |=> out_valid_q) else $error("output register not filled");

endmodule
